@@ hdl/bgnc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary grid neighbor count: shared definitions
// Field widths, register indexes, reset values, the result beat layout and
// the control bundles that travel between the units of the block.
// ----------------------------------------------------------------------------
package bgnc_pkg;

  // Field widths fixed by the interface.
  localparam int ROW_W      = 10;
  localparam int CFG_COLS_W = 8;
  localparam int OUT_COL_W  = 7;
  localparam int COUNT_W    = 4;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  // Default line buffer depth.
  localparam int MAX_COLS_DEF = 128;

  // Smallest grid side and the largest 3x3 sum.
  localparam int MIN_DIM   = 3;
  localparam int MAX_COUNT = 9;

  // Register reset values.
  localparam logic [ROW_W-1:0]      ROWS_RST = ROW_W'(8);
  localparam logic [CFG_COLS_W-1:0] COLS_RST = CFG_COLS_W'(8);

  // Result queue depth (a power of two) and its pointer and fill widths.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_e;

  // One result beat.
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic [COUNT_W-1:0]   count;
    logic                 run_end;
    logic                 frame_end;
  } result_t;

  // Cell in flight between the address stage and the window stage.
  typedef struct packed {
    logic                 valid;
    logic                 cell_val;
    logic                 top_en;
    logic                 first_col;
    logic                 emit;
    logic                 row_end;
    logic                 frame_last;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } stage_t;

  // Up to two results pushed into the queue in one cycle.
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

  // Number of set bits in a 3x3 window.
  function automatic logic [COUNT_W-1:0] popcount9(input logic [8:0] w);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + COUNT_W'(w[i]);
    end
    return n;
  endfunction

endpackage

@@ hdl/binary_grid_neighbor_count_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary grid neighbor count unit
// Streaming 3x3 box sum over a binary grid arriving in raster order.
// ----------------------------------------------------------------------------
// The block takes one cell per clock while the result queue has room, and
// gives the 3x3 sum of cell (r-1,c-1) when cell (r,c) arrives, plus a second
// result at each row end; after the last row the source sends one tail row,
// as wide as the clamped column count, to flush it. A cell passes an address
// stage, which addresses the line buffer memory, and a window stage, which
// reads it, updates the window and writes the column back; its results go
// into the output queue, whose head drives the output ports.
// The input stalls only when the eight-entry result queue cannot take the
// two results of a new cell on top of the two of the cell still in flight,
// which happens when the consumer holds off. No clearing pass is needed
// after reset: line buffer entries are always rewritten by the first two
// rows of a frame before they reach a result. A configuration write
// restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module binary_grid_neighbor_count_unit #(
  parameter int MAX_COLS = bgnc_pkg::MAX_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                cfg_we_i,
  input  logic [bgnc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bgnc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cell_req_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bgnc_pkg::ROW_W-1:0]          out_row_o,
  output logic [bgnc_pkg::OUT_COL_W-1:0]      out_col_o,
  output logic [bgnc_pkg::COUNT_W-1:0]        count_o,
  output logic                                run_end_o,
  output logic                                frame_end_o
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int CW     = (ADDR_W + 1 > bgnc_pkg::CFG_COLS_W) ? ADDR_W + 1
                                                               : bgnc_pkg::CFG_COLS_W;
  localparam int ROW_W  = bgnc_pkg::ROW_W;
  localparam int CNT_W  = bgnc_pkg::FIFO_CNT_W;

  logic [ROW_W-1:0]                grid_rows_q;
  logic [bgnc_pkg::CFG_COLS_W-1:0] grid_cols_q;
  logic                            restart;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]  eff_rows;
  logic [CW-1:0]     cols_ext;
  logic [CW-1:0]     eff_cols;
  logic [CW-1:0]     last_col;
  logic [CW-1:0]     col_ext;
  logic              row_end;
  logic              in_accept;

  bgnc_pkg::stage_t  stage_q, stage_d;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [1:0]        line_rd;
  logic [1:0]        line_wr;
  bgnc_pkg::push_t   push;
  bgnc_pkg::result_t head;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W:0]    fill_need;

  // Configuration registers; any write restarts the frame.
  assign restart = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= bgnc_pkg::ROWS_RST;
      grid_cols_q <= bgnc_pkg::COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bgnc_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data_i[ROW_W-1:0];
        bgnc_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data_i[bgnc_pkg::CFG_COLS_W-1:0];
      endcase
    end
  end

  // Effective grid size: at least three on each side, columns up to the depth.
  assign eff_rows = (grid_rows_q < ROW_W'(bgnc_pkg::MIN_DIM)) ? ROW_W'(bgnc_pkg::MIN_DIM)
                                                              : grid_rows_q;
  assign cols_ext = CW'(grid_cols_q);
  always_comb begin
    if (cols_ext < CW'(bgnc_pkg::MIN_DIM)) begin
      eff_cols = CW'(bgnc_pkg::MIN_DIM);
    end else if (cols_ext > CW'(MAX_COLS)) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = cols_ext;
    end
  end
  assign last_col = eff_cols - 1'b1;
  assign col_ext  = CW'(col_q);
  assign row_end  = (col_ext == last_col);

  // Room for two results of the cell in flight and two of the new one.
  assign fill_need  = {1'b0, fifo_count} + (stage_q.valid ? (CNT_W + 1)'(2) : '0);
  assign in_stall_o = (fill_need > (CNT_W + 1)'(bgnc_pkg::FIFO_DEPTH - 2));
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Raster position of the next cell; the tail row wraps back to row 0.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = (row_q == eff_rows) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (restart) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Address stage: classify the cell while the line buffer is read.
  always_comb begin
    stage_d.valid      = in_accept;
    stage_d.cell_val   = (row_q < eff_rows) ? cell_req_i : 1'b0;
    stage_d.top_en     = (row_q >= ROW_W'(2));
    stage_d.first_col  = (col_q == '0);
    stage_d.emit       = (row_q != '0) && (col_q != '0);
    stage_d.row_end    = row_end;
    stage_d.frame_last = (row_q == eff_rows);
    stage_d.row        = row_q - 1'b1;
    stage_d.col        = col_ext[bgnc_pkg::OUT_COL_W-1:0];
  end

  // Stage register: a restart drops the valid flag, the rest follows each
  // accepted cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= '0;
      wr_addr_q <= '0;
    end else begin
      if (restart) begin
        stage_q.valid <= 1'b0;
      end else begin
        stage_q.valid <= stage_d.valid;
      end
      if (in_accept) begin
        stage_q.cell_val   <= stage_d.cell_val;
        stage_q.top_en     <= stage_d.top_en;
        stage_q.first_col  <= stage_d.first_col;
        stage_q.emit       <= stage_d.emit;
        stage_q.row_end    <= stage_d.row_end;
        stage_q.frame_last <= stage_d.frame_last;
        stage_q.row        <= stage_d.row;
        stage_q.col        <= stage_d.col;
        wr_addr_q          <= col_q;
      end
    end
  end

  // Line buffers. The write-back follows the read via the stage register; the
  // same column is read again at least three cells later, so no forwarding.
  bgnc_line_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (stage_q.valid),
    .wr_addr_i (wr_addr_q),
    .wr_data_i (line_wr)
  );

  // Window update and result forming.
  bgnc_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .stage_i   (stage_q),
    .line_rd_i (line_rd),
    .line_wr_o (line_wr),
    .push_o    (push)
  );

  // Result queue and output channel.
  bgnc_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (~out_stall_i),
    .head_o  (head),
    .count_o (fifo_count)
  );

  assign out_valid_o = (fifo_count != '0);
  assign out_row_o   = head.row;
  assign out_col_o   = head.col;
  assign count_o     = head.count;
  assign run_end_o   = head.run_end;
  assign frame_end_o = head.frame_end;

endmodule

@@ hdl/bgnc_line_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line buffer memory
// One entry per column holding the cells of the two previous rows:
// bit 1 is the older row, bit 0 the newer row. Synchronous read.
// ----------------------------------------------------------------------------
module bgnc_line_mem #(
  parameter int MAX_COLS = bgnc_pkg::MAX_COLS_DEF,
  localparam int ADDR_W  = $clog2(MAX_COLS)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [1:0]        rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [1:0]        wr_data_i
);

  logic [1:0] mem [MAX_COLS];
  logic [1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/bgnc_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window stage
// Builds the new column from the line buffer read and the incoming cell,
// shifts it into the 3x3 window, forms the results and the write-back word.
// ----------------------------------------------------------------------------
module bgnc_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  bgnc_pkg::stage_t stage_i,
  input  logic [1:0]       line_rd_i,
  output logic [1:0]       line_wr_o,
  output bgnc_pkg::push_t  push_o
);

  logic       mid;
  logic       top;
  logic [2:0] col_bits;
  logic [8:0] win_q;
  logic [8:0] win_d;
  logic [8:0] win_tail;

  // New column: top row in bit 0, middle in bit 1, current cell in bit 2.
  assign mid      = line_rd_i[0];
  assign top      = line_rd_i[1] & stage_i.top_en;
  assign col_bits = {stage_i.cell_val, mid, top};

  // Shift the window; the first column of a row starts it afresh.
  assign win_d    = stage_i.first_col ? {6'b000000, col_bits} : {win_q[5:0], col_bits};
  // Row-end window: the column past the right edge counts as zero.
  assign win_tail = {win_d[5:0], 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart_i) begin
      win_q <= '0;
    end else if (stage_i.valid) begin
      win_q <= win_d;
    end
  end

  // Rows move down by one: the newer row becomes the older one.
  assign line_wr_o = {mid, stage_i.cell_val};

  // Result for the cell one column back, and at the row end the last column.
  always_comb begin
    push_o.v0           = stage_i.valid & stage_i.emit;
    push_o.r0.row       = stage_i.row;
    push_o.r0.col       = stage_i.col - 1'b1;
    push_o.r0.count     = bgnc_pkg::popcount9(win_d);
    push_o.r0.run_end   = ~stage_i.row_end;
    push_o.r0.frame_end = 1'b0;
    push_o.v1           = stage_i.valid & stage_i.emit & stage_i.row_end;
    push_o.r1.row       = stage_i.row;
    push_o.r1.col       = stage_i.col;
    push_o.r1.count     = bgnc_pkg::popcount9(win_tail);
    push_o.r1.run_end   = 1'b1;
    push_o.r1.frame_end = stage_i.frame_last;
  end

endmodule

@@ hdl/bgnc_result_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results a cycle and, unless the output
// stalls, hands out one beat a cycle. The head entry is seen on the ports.
// ----------------------------------------------------------------------------
module bgnc_result_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bgnc_pkg::push_t                     push_i,
  input  logic                                pop_i,
  output bgnc_pkg::result_t                   head_o,
  output logic [bgnc_pkg::FIFO_CNT_W-1:0]     count_o
);

  localparam int PTR_W = bgnc_pkg::FIFO_PTR_W;
  localparam int CNT_W = bgnc_pkg::FIFO_CNT_W;

  bgnc_pkg::result_t mem [bgnc_pkg::FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign pop    = pop_i & (count_q != '0);

  // Storage: the second result lands just behind the first.
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem[wr_ptr_q + PTR_W'(push_i.v0)] <= push_i.r1;
    end
  end

  // Pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o  = mem[rd_ptr_q];
  assign count_o = count_q;

endmodule

@@ hdl/bgnc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary grid neighbor count checker
// Port-level checks on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
module bgnc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [bgnc_pkg::ROW_W-1:0]     out_row_o,
  input logic [bgnc_pkg::OUT_COL_W-1:0] out_col_o,
  input logic [bgnc_pkg::COUNT_W-1:0]   count_o,
  input logic                           run_end_o,
  input logic                           frame_end_o
);

  logic                           out_beat;
  logic                           pend_q;
  logic [bgnc_pkg::ROW_W-1:0]     row_q;
  logic [bgnc_pkg::OUT_COL_W-1:0] col_q;

  assign out_beat = out_valid_o & ~out_stall_i;

  // Remember a beat that announced a second result from the same cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (out_beat) begin
      pend_q <= ~run_end_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_beat) begin
      row_q <= out_row_o;
      col_q <= out_col_o;
    end
  end

  // A stalled beat holds its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({out_row_o, out_col_o, count_o, run_end_o, frame_end_o}))
    else $error("stalled output beat changed");

  // A 3x3 sum never exceeds nine.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= bgnc_pkg::COUNT_W'(bgnc_pkg::MAX_COUNT))
    else $error("neighbor count out of range");

  // The frame's final result also closes its run.
  a_frame_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_end_o)
    else $error("frame end without run end");

  // The row-end pair covers the last two columns of the same row.
  a_row_end_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && pend_q |-> run_end_o && out_row_o == row_q &&
      out_col_o == col_q + 1'b1)
    else $error("row-end result does not follow its partner");

endmodule

bind binary_grid_neighbor_count_unit bgnc_checker u_bgnc_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the binary grid neighbor count unit
// Streams binary grids in raster order, each followed by its tail row, through
// the block and checks every result beat against a cycle-free model of the
// streaming 3x3 box sum. It covers the minimum, clamped and widest grids,
// partial frames cut short by a configuration write, and random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int GRID_MAX_COLS = bgnc_pkg::MAX_COLS_DEF;
  localparam int ROW_W         = bgnc_pkg::ROW_W;
  localparam int OUT_COL_W     = bgnc_pkg::OUT_COL_W;
  localparam int COUNT_W       = bgnc_pkg::COUNT_W;
  localparam int CFG_DATA_W    = bgnc_pkg::CFG_DATA_W;
  localparam int MIN_DIM       = bgnc_pkg::MIN_DIM;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;

  // Model of the 3x3 sum stream and the queue of sums still due from the block.
  class grid_sum_board;
    bit                  older_row[GRID_MAX_COLS];
    bit                  newer_row[GRID_MAX_COLS];
    logic [8:0]          window;
    int unsigned         row_pos;
    int unsigned         col_pos;
    logic [ROW_W-1:0]    rows_reg;
    logic [7:0]          cols_reg;
    bgnc_pkg::result_t   sums_due[$];
    int unsigned         mismatches;
    int unsigned         sums_checked;
    int unsigned         frames_closed;

    function new();
      rows_reg = bgnc_pkg::ROWS_RST;
      cols_reg = bgnc_pkg::COLS_RST;
      restart_frame();
    endfunction

    function void restart_frame();
      window  = '0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int unsigned rows_eff();
      return (rows_reg < MIN_DIM) ? MIN_DIM : rows_reg;
    endfunction

    function int unsigned cols_eff();
      if (cols_reg < MIN_DIM) return MIN_DIM;
      if (cols_reg > GRID_MAX_COLS) return GRID_MAX_COLS;
      return cols_reg;
    endfunction

    // A register write restarts the frame; the line buffers keep their bits.
    function void write_reg(bgnc_pkg::cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == bgnc_pkg::REG_GRID_ROWS) rows_reg = data;
      else cols_reg = data[7:0];
      restart_frame();
    endfunction

    // Shift one accepted cell into the window and queue the sums it completes.
    function void note_cell(bit cell_in);
      int unsigned       rows, cols, r, c;
      bit                cell_bit, top_bit, mid_bit, row_end;
      bgnc_pkg::result_t sum;
      rows = rows_eff();
      cols = cols_eff();
      r = row_pos;
      c = col_pos;
      if (c >= cols) c = 0;
      if (r > rows) r = 0;
      // Tail row cells count as zero; the row above row 0 counts as zero too.
      cell_bit = (r < rows) ? cell_in : 1'b0;
      top_bit  = (r >= 2) ? older_row[c] : 1'b0;
      mid_bit  = newer_row[c];
      if (c == 0) window = {6'b0, cell_bit, mid_bit, top_bit};
      else window = {window[5:0], cell_bit, mid_bit, top_bit};
      older_row[c] = newer_row[c];
      newer_row[c] = cell_bit;
      if (r >= 1 && c >= 1) begin
        row_end = (c == cols - 1);
        sum.row       = ROW_W'(r - 1);
        sum.col       = OUT_COL_W'(c - 1);
        sum.count     = COUNT_W'($countones(window));
        sum.run_end   = !row_end;
        sum.frame_end = 1'b0;
        sums_due.push_back(sum);
        // The last column of a row also closes the sum of that last column itself.
        if (row_end) begin
          sum.row       = ROW_W'(r - 1);
          sum.col       = OUT_COL_W'(c);
          sum.count     = COUNT_W'($countones({window[5:0], 3'b000}));
          sum.run_end   = 1'b1;
          sum.frame_end = (r == rows);
          sums_due.push_back(sum);
          if (r == rows) frames_closed++;
        end
      end
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
        if (r > rows) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    // Compare one result beat with the oldest sum due.
    function void check_result(bgnc_pkg::result_t got);
      bgnc_pkg::result_t want;
      if (sums_due.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d count %0d",
               got.row, got.col, got.count);
        mismatches++;
        return;
      end
      want = sums_due.pop_front();
      sums_checked++;
      if (got.row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("out_col: expected %0d, actual %0d", want.col, got.col);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        mismatches++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0d, actual %0d", want.run_end, got.run_end);
        mismatches++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  bgnc_pkg::cfg_reg_e         cfg_idx = bgnc_pkg::REG_GRID_ROWS;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cell_req = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ROW_W-1:0]           out_row;
  logic [OUT_COL_W-1:0]       out_col;
  logic [COUNT_W-1:0]         count;
  logic                       run_end;
  logic                       frame_end;

  int unsigned                src_gap_pct = 0;
  int unsigned                dst_stall_pct = 0;
  int unsigned                cycle_count = 0;
  int unsigned                cells_sent = 0;
  int unsigned                settings_run = 0;
  grid_sum_board              board = new();

  binary_grid_neighbor_count_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cell_req_i  (cell_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .count_o     (count),
    .run_end_o   (run_end),
    .frame_end_o (frame_end)
  );

  always #6 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // The receiver holds off at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    bgnc_pkg::result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.row       = out_row;
      got.col       = out_col;
      got.count     = count;
      got.run_end   = run_end;
      got.frame_end = frame_end;
      board.check_result(got);
    end
  end

  // Offer one cell, with a random gap first, and hold it until accepted.
  task automatic push_cell(bit value);
    if ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    in_valid <= 1'b1;
    cell_req <= value;
    do @(posedge clk); while (in_stall);
    board.note_cell(value);
    cells_sent++;
  endtask

  task automatic send_cells(int unsigned n, int unsigned ones_pct);
    for (int unsigned i = 0; i < n; i++) begin
      push_cell($urandom_range(99) < ones_pct);
    end
  endtask

  // Go idle and wait until every sum has come out and the pipeline is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both grid registers, in a random order, on back-to-back edges.
  task automatic config_grid(logic [CFG_DATA_W-1:0] rows_val,
                             logic [CFG_DATA_W-1:0] cols_val);
    bgnc_pkg::cfg_reg_e    first_reg, second_reg;
    logic [CFG_DATA_W-1:0] first_val, second_val;
    if ($urandom_range(1)) begin
      first_reg  = bgnc_pkg::REG_GRID_COLS;
      first_val  = cols_val;
      second_reg = bgnc_pkg::REG_GRID_ROWS;
      second_val = rows_val;
    end else begin
      first_reg  = bgnc_pkg::REG_GRID_ROWS;
      first_val  = rows_val;
      second_reg = bgnc_pkg::REG_GRID_COLS;
      second_val = cols_val;
    end
    cfg_we   <= 1'b1;
    cfg_idx  <= first_reg;
    cfg_data <= first_val;
    @(posedge clk);
    board.write_reg(first_reg, first_val);
    cfg_idx  <= second_reg;
    cfg_data <= second_val;
    @(posedge clk);
    board.write_reg(second_reg, second_val);
    cfg_we <= 1'b0;
  endtask

  // One grid setting: whole frames with random density, then a cut-off frame if asked.
  task automatic run_setting(logic [CFG_DATA_W-1:0] rows_val,
                             logic [CFG_DATA_W-1:0] cols_val,
                             int unsigned frames, int unsigned partial_cells);
    settle();
    config_grid(rows_val, cols_val);
    settings_run++;
    for (int unsigned f = 0; f < frames; f++) begin
      send_cells((board.rows_eff() + 1) * board.cols_eff(), $urandom_range(100));
    end
    if (partial_cells != 0) send_cells(partial_cells, $urandom_range(100));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct   = 14;
    dst_stall_pct = 56;

    // Directed: reset size with a full first row and the start of the second,
    // then the smallest grid reached through clamped register values, all
    // mines, tail row included.
    send_cells(10, 100);
    settle();
    config_grid(10'd0, 10'd2);
    send_cells(12, 100);
    settle();
    config_grid(10'd3, 10'd3);
    send_cells(12, 0);

    // Small grids, the reset size and a tall grid cut short.
    run_setting(10'd4, 10'd5, 2, 0);
    run_setting(10'd8, 10'd8, 1, 0);
    run_setting(10'd1, 10'd0, 2, 5);
    run_setting(10'd1023, 10'd3, 0, 24);

    // Sender idles more than the receiver.
    src_gap_pct   = 56;
    dst_stall_pct = 14;
    run_setting(10'd1, 10'h3FF, 1, 0);
    run_setting(10'd6, 10'd7, 1, 0);
    run_setting(10'd5, 10'd1, 1, 7);

    // No idling, random small grids and the widest legal grid.
    src_gap_pct   = 0;
    dst_stall_pct = 0;
    for (int k = 0; k < 3; k++) begin
      run_setting(CFG_DATA_W'($urandom_range(6)), CFG_DATA_W'($urandom_range(9)), 1,
                  $urandom_range(12));
    end
    run_setting(10'd3, 10'd128, 0, 140);

    settle();
    repeat (TAIL_CYCLES - DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d cells over %0d grid settings; checked %0d sums, %0d full frames.",
             cells_sent, settings_run, board.sums_checked, board.frames_closed);
    $display("Grids ranged from clamped 3x3 through 8x8 to 128 columns and 1023 rows.");
    if (board.mismatches == 0 && board.sums_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
